/* rtl/convex_layer_point_depth_top_assert.svh */
// ----------------------------------------------------------------------------
// convex layer point depth assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef CONVEX_LAYER_POINT_DEPTH_TOP_ASSERT_SVH
`define CONVEX_LAYER_POINT_DEPTH_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CLPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clpd check failed");
`define CLPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clpd check failed");
`else
`define CLPD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CLPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/clpd_pkg.sv */
// ----------------------------------------------------------------------------
// clpd_pkg
// shared types, constants and controller/datapath command format
// ----------------------------------------------------------------------------
package clpd_pkg;

   localparam int MAX_POINTS = 256;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int LAYER_MAX  = MAX_POINTS / 2;
   localparam int LAYER_W    = $clog2(LAYER_MAX);
   localparam int LC_W       = LAYER_W + 1;
   localparam int DEPTH_W    = 9;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_BUILD = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_BUILT = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } pt_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      pt_type           pt;
   } live_type;

   typedef enum logic [2:0] {
      SRC_IN, SRC_PT, SRC_LIVE, SRC_UP, SRC_DN, SRC_LAY, SRC_P1, SRC_P2
   } src_type;

   typedef struct packed {
      logic [CNT_W-1:0] raddr;
      logic             pt_by_idx;
      logic [CNT_W-1:0] waddr;
      logic [CNT_W-1:0] wval;
      logic             we_pt;
      logic             we_srt;
      logic             srt_new;
      logic             we_live;
      logic             we_up;
      logic             we_dn;
      logic             we_lay;
      logic             lay_dn;
      logic             we_lend;
      logic             ld_a;
      logic             ld_b;
      logic             ld_c;
      logic             ld_p1;
      logic             ld_p2;
      src_type          src_a;
      src_type          src_b;
      src_type          src_c;
      logic             alive_set;
      logic             alive_clr;
      logic             cross_go;
   } dp_cmd_type;

   typedef struct packed {
      logic             alive_srt;
      logic             alive_c;
      logic             eq_bc;
      logic             lt_cb;
      logic             x_done;
      logic             x_neg;
      logic             x_pos;
      logic             x_zero;
      logic [CNT_W-1:0] lend_q;
   } dp_sts_type;

   typedef enum logic [5:0] {
      S_IDLE, S_LD_WR, S_LD_CHK, S_LD_PTR, S_LD_CMP, S_LD_DEC, S_LD_PUT,
      S_B_INIT, S_CP_START, S_CP_RD, S_CP_PT, S_CP_WR, S_CP_END,
      S_HL_P1, S_HL_P2, S_PT_RD, S_PT_LD, S_PT_X, S_PT_W,
      S_UP_CHK, S_UP_RA, S_UP_RB, S_UP_X, S_UP_W, S_UP_PUSH,
      S_DN_CHK, S_DN_RA, S_DN_RB, S_DN_X, S_DN_W, S_DN_PUSH,
      S_EMIT, S_EU_RD, S_EU_WR, S_ED_INIT, S_ED_RD, S_ED_WR, S_LST,
      S_R1_RD, S_R1_LD, S_R1_JRD, S_R1_JLD, S_R1_CMP,
      S_R2_RD, S_R2_LD, S_R2_CHK, S_R2_JRD, S_R2_JA, S_R2_JB, S_R2_X, S_R2_W,
      S_BDONE, S_Q_L, S_Q_E, S_Q_RD, S_Q_A, S_Q_B, S_Q_X, S_Q_W, S_FIN
   } ctl_state_type;

endpackage

/* rtl/clpd_cross.sv */
// ----------------------------------------------------------------------------
// clpd_cross
// three stage orientation unit: sign of (b-a) x (c-a)
// ----------------------------------------------------------------------------
module clpd_cross (
   input  logic             clock,
   input  logic             reset,
   input  logic             go_i,
   input  clpd_pkg::pt_type a_i,
   input  clpd_pkg::pt_type b_i,
   input  clpd_pkg::pt_type c_i,
   output logic             done_o,
   output logic             neg_o,
   output logic             zero_o
);
   import clpd_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic signed [PW:0]   diff;
   logic                 neg_ff, zero_ff;
   logic [2:0]           v_ff;

   assign diff = (PW+1)'(p1_ff) - (PW+1)'(p2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], go_i};
      end
   end

   always_ff @(posedge clock) begin
      d1x_ff  <= DW'(b_i.x) - DW'(a_i.x);
      d1y_ff  <= DW'(b_i.y) - DW'(a_i.y);
      d2x_ff  <= DW'(c_i.x) - DW'(a_i.x);
      d2y_ff  <= DW'(c_i.y) - DW'(a_i.y);
      p1_ff   <= d1x_ff * d2y_ff;
      p2_ff   <= d1y_ff * d2x_ff;
      if (v_ff[1]) begin
         neg_ff  <= diff[PW];
         zero_ff <= (diff == '0);
      end
   end

   assign done_o = v_ff[2];
   assign neg_o  = neg_ff;
   assign zero_o = zero_ff;

endmodule

/* rtl/clpd_dpath.sv */
// ----------------------------------------------------------------------------
// clpd_dpath
// point, order, chain and layer memories, operand registers, alive flags
// ----------------------------------------------------------------------------
module clpd_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  clpd_pkg::dp_cmd_type cmd_i,
   input  clpd_pkg::pt_type     in_pt_i,
   output clpd_pkg::dp_sts_type sts_o
);
   import clpd_pkg::*;

   pt_type           pt_mem   [MAX_POINTS];
   logic [IDX_W-1:0] srt_mem  [MAX_POINTS];
   live_type         live_mem [MAX_POINTS];
   pt_type           up_mem   [MAX_POINTS];
   pt_type           dn_mem   [MAX_POINTS];
   pt_type           lay_mem  [MAX_POINTS];
   logic [CNT_W-1:0] lend_mem [LAYER_MAX];

   pt_type           pt_q_ff, up_q_ff, dn_q_ff, lay_q_ff;
   logic [IDX_W-1:0] srt_q_ff;
   live_type         live_q_ff;
   logic [CNT_W-1:0] lend_q_ff;

   pt_type           a_ff, b_ff, c_ff, p1_ff, p2_ff;
   logic [IDX_W-1:0] c_idx_ff;
   logic [MAX_POINTS-1:0] alive_ff;

   logic [IDX_W-1:0] ra, wa, pt_addr;
   pt_type           src_val [8];
   logic             x_done, x_neg, x_zero;

   assign ra      = cmd_i.raddr[IDX_W-1:0];
   assign wa      = cmd_i.waddr[IDX_W-1:0];
   assign pt_addr = cmd_i.pt_by_idx ? srt_q_ff : ra;

   always_ff @(posedge clock) begin
      if (cmd_i.we_pt) pt_mem[wa] <= c_ff;
      pt_q_ff <= pt_mem[pt_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd_i.we_srt) srt_mem[wa] <= cmd_i.srt_new ? cmd_i.wval[IDX_W-1:0] : srt_q_ff;
      srt_q_ff <= srt_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (cmd_i.we_live) live_mem[wa] <= '{idx: srt_q_ff, pt: pt_q_ff};
      live_q_ff <= live_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (cmd_i.we_up) up_mem[wa] <= c_ff;
      up_q_ff <= up_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (cmd_i.we_dn) dn_mem[wa] <= c_ff;
      dn_q_ff <= dn_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (cmd_i.we_lay) lay_mem[wa] <= cmd_i.lay_dn ? dn_q_ff : up_q_ff;
      lay_q_ff <= lay_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (cmd_i.we_lend) lend_mem[cmd_i.waddr[LAYER_W-1:0]] <= cmd_i.wval;
      lend_q_ff <= lend_mem[cmd_i.raddr[LAYER_W-1:0]];
   end

   always_comb begin
      src_val[SRC_IN]   = in_pt_i;
      src_val[SRC_PT]   = pt_q_ff;
      src_val[SRC_LIVE] = live_q_ff.pt;
      src_val[SRC_UP]   = up_q_ff;
      src_val[SRC_DN]   = dn_q_ff;
      src_val[SRC_LAY]  = lay_q_ff;
      src_val[SRC_P1]   = p1_ff;
      src_val[SRC_P2]   = p2_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd_i.ld_a)  a_ff  <= src_val[cmd_i.src_a];
      if (cmd_i.ld_b)  b_ff  <= src_val[cmd_i.src_b];
      if (cmd_i.ld_c)  c_ff  <= src_val[cmd_i.src_c];
      if (cmd_i.ld_c && cmd_i.src_c == SRC_LIVE) c_idx_ff <= live_q_ff.idx;
      if (cmd_i.ld_p1) p1_ff <= live_q_ff.pt;
      if (cmd_i.ld_p2) p2_ff <= live_q_ff.pt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= '0;
      end else if (cmd_i.alive_set) begin
         alive_ff <= '1;
      end else if (cmd_i.alive_clr) begin
         alive_ff[c_idx_ff] <= 1'b0;
      end
   end

   clpd_cross u_cross (
      .clock  (clock),
      .reset  (reset),
      .go_i   (cmd_i.cross_go),
      .a_i    (a_ff),
      .b_i    (b_ff),
      .c_i    (c_ff),
      .done_o (x_done),
      .neg_o  (x_neg),
      .zero_o (x_zero)
   );

   always_comb begin
      sts_o.alive_srt = alive_ff[srt_q_ff];
      sts_o.alive_c   = alive_ff[c_idx_ff];
      sts_o.eq_bc     = (b_ff == c_ff);
      sts_o.lt_cb     = (c_ff.x < b_ff.x) || (c_ff.x == b_ff.x && c_ff.y < b_ff.y);
      sts_o.x_done    = x_done;
      sts_o.x_neg     = x_neg;
      sts_o.x_pos     = !x_neg && !x_zero;
      sts_o.x_zero    = x_zero;
      sts_o.lend_q    = lend_q_ff;
   end

endmodule

/* rtl/clpd_ctrl.sv */
// ----------------------------------------------------------------------------
// clpd_ctrl
// sequencer for load insertion, hull peeling and depth queries
// ----------------------------------------------------------------------------
`include "convex_layer_point_depth_top_assert.svh"

module clpd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [clpd_pkg::DEPTH_W-1:0] rsp_depth,
   output clpd_pkg::status_type        rsp_status,
   output clpd_pkg::dp_cmd_type        cmd_o,
   input  clpd_pkg::dp_sts_type        sts_i
);
   import clpd_pkg::*;

   ctl_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, i_ff, i_in, j_ff, j_in, m_ff, m_in;
   logic [CNT_W-1:0] nu_ff, nu_in, nd_ff, nd_in, vt_ff, vt_in, k_ff, k_in;
   logic [CNT_W-1:0] st_ff, st_in, e_ff, e_in;
   logic [DEPTH_W-1:0] d_ff, d_in, rsp_depth_ff, rsp_depth_in;
   logic [LC_W-1:0]  lc_ff, lc_in;
   logic             built_ff, built_in, tneg_ff, tneg_in, tpos_ff, tpos_in;
   status_type       status_ff, status_in, rsp_status_ff, rsp_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_pt;
   logic [CNT_W:0]   len_w, end_w;
   logic [CNT_W-1:0] j_next, j_wrap;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_depth  = rsp_depth_ff;
   assign rsp_status = rsp_status_ff;

   assign last_pt = (i_ff == m_ff - CNT_W'(1));
   assign len_w   = {1'b0, nu_ff} + {1'b0, nd_ff} - (CNT_W+1)'(2);
   assign end_w   = {1'b0, vt_ff} + len_w;
   assign j_next  = j_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         lc_ff        <= '0;
         vt_ff        <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lc_ff        <= lc_in;
         vt_ff        <= vt_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      m_ff          <= m_in;
      nu_ff         <= nu_in;
      nd_ff         <= nd_in;
      k_ff          <= k_in;
      st_ff         <= st_in;
      e_ff          <= e_in;
      d_ff          <= d_in;
      tneg_ff       <= tneg_in;
      tpos_ff       <= tpos_in;
      status_ff     <= status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      m_in          = m_ff;
      nu_in         = nu_ff;
      nd_in         = nd_ff;
      vt_in         = vt_ff;
      k_in          = k_ff;
      st_in         = st_ff;
      e_in          = e_ff;
      d_in          = d_ff;
      lc_in         = lc_ff;
      built_in      = built_ff;
      tneg_in       = tneg_ff;
      tpos_in       = tpos_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      j_wrap        = '0;
      cmd_o         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_o.ld_c  = 1'b1;
               cmd_o.src_c = SRC_IN;
               d_in        = '0;
               status_in   = ST_OK;
               case (cmd_type'(req_tuser))
                  CMD_CLEAR: begin
                     count_in = '0;
                     lc_in    = '0;
                     vt_in    = '0;
                     built_in = 1'b0;
                     state_in = S_FIN;
                  end
                  CMD_LOAD: begin
                     if (count_ff == CNT_W'(MAX_POINTS)) begin
                        status_in = ST_FULL;
                        state_in  = S_FIN;
                     end else begin
                        built_in = 1'b0;
                        j_in     = count_ff;
                        state_in = S_LD_WR;
                     end
                  end
                  CMD_BUILD: state_in = S_B_INIT;
                  CMD_QUERY: begin
                     if (!built_ff) begin
                        status_in = ST_NOT_BUILT;
                        state_in  = S_FIN;
                     end else begin
                        st_in    = '0;
                        i_in     = '0;
                        state_in = S_Q_L;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end

         // insertion into the x-then-y order, equal keys stay behind
         S_LD_WR: begin
            cmd_o.we_pt = 1'b1;
            cmd_o.waddr = count_ff;
            state_in    = S_LD_CHK;
         end
         S_LD_CHK: begin
            cmd_o.raddr = j_ff - CNT_W'(1);
            state_in    = (j_ff == '0) ? S_LD_PUT : S_LD_PTR;
         end
         S_LD_PTR: begin
            cmd_o.raddr     = j_ff - CNT_W'(1);
            cmd_o.pt_by_idx = 1'b1;
            state_in        = S_LD_CMP;
         end
         S_LD_CMP: begin
            cmd_o.raddr = j_ff - CNT_W'(1);
            cmd_o.ld_b  = 1'b1;
            cmd_o.src_b = SRC_PT;
            state_in    = S_LD_DEC;
         end
         S_LD_DEC: begin
            cmd_o.raddr = j_ff - CNT_W'(1);
            if (sts_i.lt_cb) begin
               cmd_o.we_srt = 1'b1;
               cmd_o.waddr  = j_ff;
               j_in         = j_ff - CNT_W'(1);
               state_in     = S_LD_CHK;
            end else begin
               state_in = S_LD_PUT;
            end
         end
         S_LD_PUT: begin
            cmd_o.we_srt  = 1'b1;
            cmd_o.srt_new = 1'b1;
            cmd_o.waddr   = j_ff;
            cmd_o.wval    = count_ff;
            count_in      = count_ff + CNT_W'(1);
            state_in      = S_FIN;
         end

         S_B_INIT: begin
            cmd_o.alive_set = 1'b1;
            lc_in           = '0;
            vt_in           = '0;
            state_in        = S_CP_START;
         end

         // gather the live points in sorted order
         S_CP_START: begin
            i_in     = '0;
            m_in     = '0;
            state_in = S_CP_RD;
         end
         S_CP_RD: begin
            cmd_o.raddr = i_ff;
            state_in    = (i_ff == count_ff) ? S_CP_END : S_CP_PT;
         end
         S_CP_PT: begin
            cmd_o.raddr     = i_ff;
            cmd_o.pt_by_idx = 1'b1;
            state_in        = S_CP_WR;
         end
         S_CP_WR: begin
            cmd_o.raddr = i_ff;
            if (sts_i.alive_srt) begin
               cmd_o.we_live = 1'b1;
               cmd_o.waddr   = m_ff;
               m_in          = m_ff + CNT_W'(1);
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = S_CP_RD;
         end
         S_CP_END: begin
            cmd_o.raddr = '0;
            state_in    = (m_ff <= CNT_W'(2)) ? S_BDONE : S_HL_P1;
         end

         // monotone chains
         S_HL_P1: begin
            cmd_o.raddr = m_ff - CNT_W'(1);
            cmd_o.ld_c  = 1'b1;
            cmd_o.src_c = SRC_LIVE;
            cmd_o.ld_p1 = 1'b1;
            state_in    = S_HL_P2;
         end
         S_HL_P2: begin
            cmd_o.ld_p2 = 1'b1;
            cmd_o.we_up = 1'b1;
            cmd_o.we_dn = 1'b1;
            cmd_o.waddr = '0;
            nu_in       = CNT_W'(1);
            nd_in       = CNT_W'(1);
            i_in        = CNT_W'(1);
            state_in    = S_PT_RD;
         end
         S_PT_RD: begin
            cmd_o.raddr = i_ff;
            state_in    = (i_ff == m_ff) ? S_EMIT : S_PT_LD;
         end
         S_PT_LD: begin
            cmd_o.ld_c  = 1'b1;
            cmd_o.src_c = SRC_LIVE;
            cmd_o.ld_a  = 1'b1;
            cmd_o.src_a = SRC_P2;
            cmd_o.ld_b  = 1'b1;
            cmd_o.src_b = SRC_P1;
            state_in    = S_PT_X;
         end
         S_PT_X: begin
            cmd_o.cross_go = 1'b1;
            state_in       = S_PT_W;
         end
         S_PT_W: begin
            if (sts_i.x_done) begin
               tneg_in  = sts_i.x_neg;
               tpos_in  = sts_i.x_pos;
               state_in = S_UP_CHK;
            end
         end

         S_UP_CHK: begin
            cmd_o.raddr = nu_ff - CNT_W'(2);
            if (!(last_pt || tneg_ff)) state_in = S_DN_CHK;
            else if (nu_ff >= CNT_W'(2)) state_in = S_UP_RA;
            else state_in = S_UP_PUSH;
         end
         S_UP_RA: begin
            cmd_o.raddr = nu_ff - CNT_W'(1);
            cmd_o.ld_a  = 1'b1;
            cmd_o.src_a = SRC_UP;
            state_in    = S_UP_RB;
         end
         S_UP_RB: begin
            cmd_o.ld_b  = 1'b1;
            cmd_o.src_b = SRC_UP;
            state_in    = S_UP_X;
         end
         S_UP_X: begin
            cmd_o.cross_go = 1'b1;
            state_in       = S_UP_W;
         end
         S_UP_W: begin
            if (sts_i.x_done) begin
               if (!sts_i.x_neg) begin
                  nu_in    = nu_ff - CNT_W'(1);
                  state_in = S_UP_CHK;
               end else begin
                  state_in = S_UP_PUSH;
               end
            end
         end
         S_UP_PUSH: begin
            cmd_o.we_up = 1'b1;
            cmd_o.waddr = nu_ff;
            nu_in       = nu_ff + CNT_W'(1);
            state_in    = S_DN_CHK;
         end

         S_DN_CHK: begin
            cmd_o.raddr = nd_ff - CNT_W'(2);
            if (!(last_pt || tpos_ff)) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_PT_RD;
            end else if (nd_ff >= CNT_W'(2)) begin
               state_in = S_DN_RA;
            end else begin
               state_in = S_DN_PUSH;
            end
         end
         S_DN_RA: begin
            cmd_o.raddr = nd_ff - CNT_W'(1);
            cmd_o.ld_a  = 1'b1;
            cmd_o.src_a = SRC_DN;
            state_in    = S_DN_RB;
         end
         S_DN_RB: begin
            cmd_o.ld_b  = 1'b1;
            cmd_o.src_b = SRC_DN;
            state_in    = S_DN_X;
         end
         S_DN_X: begin
            cmd_o.cross_go = 1'b1;
            state_in       = S_DN_W;
         end
         S_DN_W: begin
            if (sts_i.x_done) begin
               if (!sts_i.x_pos) begin
                  nd_in    = nd_ff - CNT_W'(1);
                  state_in = S_DN_CHK;
               end else begin
                  state_in = S_DN_PUSH;
               end
            end
         end
         S_DN_PUSH: begin
            cmd_o.we_dn = 1'b1;
            cmd_o.waddr = nd_ff;
            nd_in       = nd_ff + CNT_W'(1);
            i_in        = i_ff + CNT_W'(1);
            state_in    = S_PT_RD;
         end

         // copy upper chain, then lower chain reversed without its ends
         S_EMIT: begin
            st_in = vt_ff;
            k_in  = '0;
            if (end_w > (CNT_W+1)'(MAX_POINTS)) state_in = S_BDONE;
            else state_in = S_EU_RD;
         end
         S_EU_RD: begin
            cmd_o.raddr = k_ff;
            state_in    = (k_ff == nu_ff) ? S_ED_INIT : S_EU_WR;
         end
         S_EU_WR: begin
            cmd_o.we_lay = 1'b1;
            cmd_o.waddr  = vt_ff;
            vt_in        = vt_ff + CNT_W'(1);
            k_in         = k_ff + CNT_W'(1);
            state_in     = S_EU_RD;
         end
         S_ED_INIT: begin
            k_in     = nd_ff - CNT_W'(1);
            state_in = S_ED_RD;
         end
         S_ED_RD: begin
            cmd_o.raddr = k_ff - CNT_W'(1);
            state_in    = (k_ff < CNT_W'(2)) ? S_LST : S_ED_WR;
         end
         S_ED_WR: begin
            cmd_o.we_lay = 1'b1;
            cmd_o.lay_dn = 1'b1;
            cmd_o.waddr  = vt_ff;
            vt_in        = vt_ff + CNT_W'(1);
            k_in         = k_ff - CNT_W'(1);
            state_in     = S_ED_RD;
         end
         S_LST: begin
            cmd_o.we_lend = 1'b1;
            cmd_o.waddr   = CNT_W'(lc_ff);
            cmd_o.wval    = vt_ff;
            lc_in         = lc_ff + LC_W'(1);
            i_in          = '0;
            state_in      = S_R1_RD;
         end

         // drop every point sharing coordinates with a hull vertex
         S_R1_RD: begin
            cmd_o.raddr = i_ff;
            if (i_ff == m_ff) begin
               i_in     = '0;
               state_in = S_R2_RD;
            end else begin
               state_in = S_R1_LD;
            end
         end
         S_R1_LD: begin
            cmd_o.ld_c  = 1'b1;
            cmd_o.src_c = SRC_LIVE;
            j_in        = st_ff;
            state_in    = S_R1_JRD;
         end
         S_R1_JRD: begin
            cmd_o.raddr = j_ff;
            if (j_ff == vt_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_R1_RD;
            end else begin
               state_in = S_R1_JLD;
            end
         end
         S_R1_JLD: begin
            cmd_o.ld_b  = 1'b1;
            cmd_o.src_b = SRC_LAY;
            state_in    = S_R1_CMP;
         end
         S_R1_CMP: begin
            if (sts_i.eq_bc) begin
               cmd_o.alive_clr = 1'b1;
               i_in            = i_ff + CNT_W'(1);
               state_in        = S_R1_RD;
            end else begin
               j_in     = j_next;
               state_in = S_R1_JRD;
            end
         end

         // drop survivors on the line of any hull edge
         S_R2_RD: begin
            cmd_o.raddr = i_ff;
            state_in    = (i_ff == m_ff) ? S_CP_START : S_R2_LD;
         end
         S_R2_LD: begin
            cmd_o.ld_c  = 1'b1;
            cmd_o.src_c = SRC_LIVE;
            j_in        = st_ff;
            state_in    = S_R2_CHK;
         end
         S_R2_CHK: begin
            if (!sts_i.alive_c) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_R2_RD;
            end else begin
               state_in = S_R2_JRD;
            end
         end
         S_R2_JRD: begin
            cmd_o.raddr = j_ff;
            if (j_ff == vt_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_R2_RD;
            end else begin
               state_in = S_R2_JA;
            end
         end
         S_R2_JA: begin
            j_wrap      = (j_next == vt_ff) ? st_ff : j_next;
            cmd_o.raddr = j_wrap;
            cmd_o.ld_a  = 1'b1;
            cmd_o.src_a = SRC_LAY;
            state_in    = S_R2_JB;
         end
         S_R2_JB: begin
            cmd_o.ld_b  = 1'b1;
            cmd_o.src_b = SRC_LAY;
            state_in    = S_R2_X;
         end
         S_R2_X: begin
            cmd_o.cross_go = 1'b1;
            state_in       = S_R2_W;
         end
         S_R2_W: begin
            if (sts_i.x_done) begin
               if (sts_i.x_zero) begin
                  cmd_o.alive_clr = 1'b1;
                  i_in            = i_ff + CNT_W'(1);
                  state_in        = S_R2_RD;
               end else begin
                  j_in     = j_next;
                  state_in = S_R2_JRD;
               end
            end
         end

         S_BDONE: begin
            built_in = 1'b1;
            state_in = S_FIN;
         end

         // walk layers from the outside, stop at the first that misses
         S_Q_L: begin
            cmd_o.raddr = i_ff;
            state_in    = (i_ff == CNT_W'(lc_ff)) ? S_FIN : S_Q_E;
         end
         S_Q_E: begin
            e_in     = sts_i.lend_q;
            j_in     = st_ff;
            state_in = S_Q_RD;
         end
         S_Q_RD: begin
            cmd_o.raddr = j_ff;
            if (j_ff == e_ff) begin
               d_in     = d_ff + DEPTH_W'(1);
               st_in    = e_ff;
               i_in     = i_ff + CNT_W'(1);
               state_in = S_Q_L;
            end else begin
               state_in = S_Q_A;
            end
         end
         S_Q_A: begin
            j_wrap      = (j_next == e_ff) ? st_ff : j_next;
            cmd_o.raddr = j_wrap;
            cmd_o.ld_a  = 1'b1;
            cmd_o.src_a = SRC_LAY;
            state_in    = S_Q_B;
         end
         S_Q_B: begin
            cmd_o.ld_b  = 1'b1;
            cmd_o.src_b = SRC_LAY;
            state_in    = S_Q_X;
         end
         S_Q_X: begin
            cmd_o.cross_go = 1'b1;
            state_in       = S_Q_W;
         end
         S_Q_W: begin
            if (sts_i.x_done) begin
               if (!sts_i.x_neg) begin
                  state_in = S_FIN;
               end else begin
                  j_in     = j_next;
                  state_in = S_Q_RD;
               end
            end
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_depth_in  = d_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   `CLPD_ASSERT_IMPL(a_err_no_depth, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_depth_ff == '0)
   `CLPD_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, state_ff != S_IDLE)
   `CLPD_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_POINTS))
   `CLPD_ASSERT_IMPL(a_vert_range, clock, reset, 1'b1, vt_ff <= CNT_W'(MAX_POINTS))

endmodule

/* rtl/convex_layer_point_depth_top.sv */
// ----------------------------------------------------------------------------
// convex_layer_point_depth_top
// onion peeling point depth: load points, peel convex layers, answer queries
// ----------------------------------------------------------------------------
//  channel  | ports | contents
//  request  | req_  | tuser: cmd[1:0]; tdata: px[15:0], py[31:16]
//  response | rsp_  | tdata: depth[8:0], zero pad; tuser: status[1:0]
//
//  one request at a time. a load writes the point, then shifts up each stored
//  point that sorts after it in the order and places its index in the gap.
//  build runs the peeling sequencer: per layer a sweep over the stored points,
//  a chain walk using the orientation unit, and removal passes that test each
//  live point against the hull vertices and then against the hull edges.
//  a query runs an orientation test per hull edge across the layers walked.
//  a result waits in the output register while the next request is taken.
//  synchronous reset clears the counters, flags and the state machine only.
// ----------------------------------------------------------------------------
module convex_layer_point_depth_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // px[15:0], py[31:16]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // depth[8:0], zero[15:9]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import clpd_pkg::*;

   dp_cmd_type           cmd;
   dp_sts_type           sts;
   pt_type               in_pt;
   logic [DEPTH_W-1:0]   depth;
   status_type           status;

   assign in_pt.x = req_tdata[COORD_BITS-1:0];
   assign in_pt.y = req_tdata[2*COORD_BITS-1:COORD_BITS];

   clpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_depth  (depth),
      .rsp_status (status),
      .cmd_o      (cmd),
      .sts_i      (sts)
   );

   clpd_dpath u_dpath (
      .clock   (clock),
      .reset   (reset),
      .cmd_i   (cmd),
      .in_pt_i (in_pt),
      .sts_o   (sts)
   );

   assign rsp_tdata = {(16 - DEPTH_W)'(0), depth};
   assign rsp_tuser = status;

endmodule

/* test/convex_layer_point_depth_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// convex_layer_point_depth_top_tb
// loads point sets, peels convex layers and checks query depth and status
// against an integer onion-peeling model kept inside the bench
// ----------------------------------------------------------------------------
module convex_layer_point_depth_top_tb;
   import clpd_pkg::*;

   localparam int NPTS      = 256;
   localparam int NLAYERS   = NPTS / 2 + 1;
   localparam int STALL_MAX = 2000000;
   localparam int HOLD_LONG = 400;

   typedef struct {
      cmd_type          cmd;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } point_req_t;

   typedef struct {
      logic [8:0]  depth;
      status_type  status;
   } depth_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   point_req_t pend_q[$];
   depth_rsp_t depth_q[$];
   int  n_total;
   int  n_sent = 0;
   int  n_rsp = 0;
   int  req_gap = 0;
   int  rsp_hold = 0;
   bit  pressure_done = 0;
   bit  failed = 0;
   int  stall_cnt = 0;

   // model state
   longint mx[NPTS];
   longint my[NPTS];
   bit     alive[NPTS];
   int     vert_list[NPTS];
   int     layer_base[NLAYERS];
   int     n_pts = 0, n_layers = 0, n_verts = 0;
   bit     is_built = 0;

   convex_layer_point_depth_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint cross3(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
      return ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
   endfunction

   function automatic longint orient(int a, int b, int c);
      return cross3(mx[a], my[a], mx[b], my[b], mx[c], my[c]);
   endfunction

   function automatic bit sorts_first(int a, int b);
      return mx[a] < mx[b] || (mx[a] == mx[b] && my[a] < my[b]);
   endfunction

   function automatic void peel_layers();
      int srt[NPTS];
      int live[NPTS];
      int up[NPTS];
      int dn[NPTS];
      int i, j, k, m, nu, nd, p1, p2, c, v, p, a, b, len, start;
      for (i = 0; i < n_pts; i++) begin
         alive[i] = 1;
         j = i;
         while (j > 0 && sorts_first(i, srt[j-1])) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = i;
      end
      n_layers = 0;
      n_verts = 0;
      while (1) begin
         m = 0;
         for (i = 0; i < n_pts; i++)
            if (alive[srt[i]]) begin
               live[m] = srt[i];
               m++;
            end
         if (m <= 2 || n_layers >= NLAYERS) break;
         p1 = live[0];
         p2 = live[m-1];
         up[0] = p1;
         dn[0] = p1;
         nu = 1;
         nd = 1;
         for (i = 1; i < m; i++) begin
            c = live[i];
            if (i == m - 1 || orient(p1, c, p2) < 0) begin
               while (nu >= 2 && !(orient(up[nu-2], up[nu-1], c) < 0)) nu--;
               up[nu] = c;
               nu++;
            end
            if (i == m - 1 || orient(p1, c, p2) > 0) begin
               while (nd >= 2 && !(orient(dn[nd-2], dn[nd-1], c) > 0)) nd--;
               dn[nd] = c;
               nd++;
            end
         end
         start = n_verts;
         len = nu + (nd >= 2 ? nd - 2 : 0);
         if (start + len > NPTS) break;
         for (i = 0; i < nu; i++) begin
            vert_list[n_verts] = up[i];
            n_verts++;
         end
         for (k = nd - 1; k >= 2; k--) begin
            vert_list[n_verts] = dn[k-1];
            n_verts++;
         end
         layer_base[n_layers] = start;
         n_layers++;
         // hull vertices and their duplicates go first
         for (i = 0; i < m; i++) begin
            p = live[i];
            for (j = 0; j < len; j++) begin
               v = vert_list[start + j];
               if (mx[p] == mx[v] && my[p] == my[v]) begin
                  alive[p] = 0;
                  break;
               end
            end
         end
         // then points lying on a hull edge line
         for (i = 0; i < m; i++) begin
            p = live[i];
            if (alive[p]) begin
               for (j = 0; j < len; j++) begin
                  a = vert_list[start + j];
                  b = vert_list[start + (j + 1) % len];
                  if (orient(a, b, p) == 0) begin
                     alive[p] = 0;
                     break;
                  end
               end
            end
         end
      end
      is_built = 1;
   endfunction

   function automatic int layer_depth(longint qx, longint qy);
      int d, l, i, s, e, n, a, b;
      bit ins;
      d = 0;
      for (l = 0; l < n_layers; l++) begin
         s = layer_base[l];
         e = (l + 1 < n_layers) ? layer_base[l+1] : n_verts;
         n = e - s;
         ins = n > 0;
         for (i = 0; i < n && ins; i++) begin
            a = vert_list[s + i];
            b = vert_list[s + (i + 1) % n];
            if (!(cross3(mx[a], my[a], mx[b], my[b], qx, qy) < 0)) ins = 0;
         end
         if (!ins) break;
         d++;
      end
      return d > 511 ? 511 : d;
   endfunction

   function automatic depth_rsp_t predict_depth(point_req_t r);
      depth_rsp_t o;
      o.depth = '0;
      o.status = ST_OK;
      case (r.cmd)
         CMD_CLEAR: begin
            n_pts = 0;
            n_layers = 0;
            n_verts = 0;
            is_built = 0;
         end
         CMD_LOAD: begin
            if (n_pts >= NPTS) o.status = ST_FULL;
            else begin
               mx[n_pts] = longint'(r.x);
               my[n_pts] = longint'(r.y);
               n_pts++;
               is_built = 0;
            end
         end
         CMD_BUILD: peel_layers();
         default: begin
            if (!is_built) o.status = ST_NOT_BUILT;
            else o.depth = 9'(layer_depth(longint'(r.x), longint'(r.y)));
         end
      endcase
      return o;
   endfunction

   function automatic void put(cmd_type c, int x, int y);
      point_req_t r;
      r.cmd = c;
      r.x = 16'(x);
      r.y = 16'(y);
      pend_q.push_back(r);
   endfunction

   function automatic int rnd_coord(int span);
      if (span >= 32768) return int'($urandom_range(0, 65535)) - 32768;
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // stimulus
   initial begin
      int k, n, span, nq, i;
      int lx[$];
      int ly[$];
      // directed part
      put(CMD_QUERY, 0, 0);             // query before any build
      put(CMD_BUILD, 0, 0);             // build on empty store
      put(CMD_QUERY, 0, 0);
      put(CMD_LOAD, 5, 5);
      put(CMD_LOAD, -5, -5);
      put(CMD_BUILD, 0, 0);             // two points, no layer
      put(CMD_QUERY, 0, 0);
      put(CMD_CLEAR, 0, 0);
      put(CMD_LOAD, -32768, -32768);
      put(CMD_LOAD, 32767, -32768);
      put(CMD_LOAD, 32767, 32767);
      put(CMD_LOAD, -32768, 32767);
      put(CMD_LOAD, 0, 0);
      put(CMD_LOAD, 0, 0);              // duplicate of an inner point
      put(CMD_LOAD, 100, 100);
      put(CMD_LOAD, -100, 100);
      put(CMD_LOAD, 0, -100);
      put(CMD_LOAD, 32767, 0);          // on an outer edge
      put(CMD_BUILD, 0, 0);
      put(CMD_QUERY, 1, 1);
      put(CMD_QUERY, 32767, 5);
      put(CMD_QUERY, -32768, -32768);
      put(CMD_LOAD, 3, 3);              // stale layers after load
      put(CMD_QUERY, 1, 1);
      put(CMD_CLEAR, 0, 0);
      // random point sets
      while (pend_q.size() < 330) begin
         if ($urandom_range(0, 3) != 0) put(CMD_CLEAR, 0, 0);
         case ($urandom_range(0, 3))
            0: span = 32768;
            1: span = 1000;
            default: span = 6;
         endcase
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 16);
         lx.delete();
         ly.delete();
         for (k = 0; k < n; k++) begin
            lx.push_back(rnd_coord(span));
            ly.push_back(rnd_coord(span));
            put(CMD_LOAD, lx[k], ly[k]);
         end
         if ($urandom_range(0, 9) == 0) put(cmd_type'($urandom_range(0, 3)),
                                            rnd_coord(32768), rnd_coord(32768));
         if ($urandom_range(0, 9) != 0) put(CMD_BUILD, 0, 0);
         nq = $urandom_range(2, 7);
         for (k = 0; k < nq; k++) begin
            if (n > 0 && $urandom_range(0, 2) == 0) begin
               i = $urandom_range(0, n - 1);
               put(CMD_QUERY, lx[i], ly[i]);
            end else if ($urandom_range(0, 1) == 0) begin
               put(CMD_QUERY, rnd_coord(span / 3), rnd_coord(span / 3));
            end else begin
               put(CMD_QUERY, rnd_coord(span), rnd_coord(span));
            end
         end
      end
      // fill the store, overflow it, peel it once
      put(CMD_CLEAR, 0, 0);
      for (k = 0; k < NPTS + 2; k++) put(CMD_LOAD, rnd_coord(20), rnd_coord(20));
      put(CMD_BUILD, 0, 0);
      for (k = 0; k < 6; k++) put(CMD_QUERY, rnd_coord(10), rnd_coord(10));
      n_total = pend_q.size();
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (n_sent < n_total - 40 && $urandom_range(0, 9) == 0) begin
            req_tvalid <= 1'b0;
            req_gap <= $urandom_range(0, 16);
         end else if (pend_q.size() > 0) begin
            point_req_t r;
            r = pend_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {r.y, r.x};
            req_tuser <= r.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // prediction on each accepted request
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         point_req_t r;
         r.cmd = cmd_type'(req_tuser);
         r.x = req_tdata[15:0];
         r.y = req_tdata[31:16];
         depth_q.push_back(predict_depth(r));
         n_sent <= n_sent + 1;
      end
   end

   // response side stalls, with one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (!pressure_done && n_rsp >= 30) begin
         pressure_done <= 1'b1;
         rsp_tready <= 1'b0;
         rsp_hold <= HOLD_LONG;
      end else if (n_sent < n_total - 40 && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= $urandom_range(0, 16);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         depth_rsp_t e;
         n_rsp <= n_rsp + 1;
         if (depth_q.size() == 0) begin
            $error("response with no request outstanding: depth %0d status %0d",
                   rsp_tdata[8:0], rsp_tuser);
            failed = 1;
         end else begin
            e = depth_q.pop_front();
            if (rsp_tdata[8:0] !== e.depth) begin
               $error("depth: expected %0d, got %0d", e.depth, rsp_tdata[8:0]);
               failed = 1;
            end
            if (rsp_tdata[15:9] !== 7'd0) begin
               $error("pad: expected 0, got %0h", rsp_tdata[15:9]);
               failed = 1;
            end
            if (rsp_tuser !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_tuser);
               failed = 1;
            end
         end
      end
   end

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (n_total == 0 || pend_q.size() > 0 || req_tvalid || depth_q.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (!failed && depth_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* convex_layer_point_depth_top.f */
+incdir+rtl
rtl/clpd_pkg.sv
rtl/clpd_cross.sv
rtl/clpd_dpath.sv
rtl/clpd_ctrl.sv
rtl/convex_layer_point_depth_top.sv
test/convex_layer_point_depth_top_tb.sv
